>>> hw/rtl/dsiv_pkg.sv
// Shared types and constants for the sector ID header validator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dsiv_pkg;

    // Opcode carried on tuser
    localparam logic OP_ENTRY = 1'b0;
    localparam logic OP_END   = 1'b1;

    localparam logic [7:0] FREE_MARK    = 8'hFF;
    localparam logic [7:0] PROTECT_ON   = 8'hFF;
    localparam logic [7:0] PROTECT_OFF  = 8'h00;
    localparam logic [11:0] COUNT_MAX   = 12'hFFF;

    // Result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_TOO_SMALL   = 3'd1;
    localparam logic [2:0] STATUS_INVALID     = 3'd2;
    localparam logic [2:0] STATUS_BAD_TRACKS  = 3'd3;
    localparam logic [2:0] STATUS_BAD_SECTORS = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ZERO_LIMIT   = 3'd0;
    localparam logic [2:0] REG_TRACK_LIMIT  = 3'd1;
    localparam logic [2:0] REG_SECTOR_LIMIT = 3'd2;
    localparam logic [2:0] REG_MAX_TRACK    = 3'd3;
    localparam logic [2:0] REG_MAX_SECTOR   = 3'd4;

    localparam int SIZE_W      = 22;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [11:0] zero_limit;
        logic [11:0] track_limit;
        logic [11:0] sector_limit;
    } limits_t;

    // One classified command from the front to the back
    typedef struct packed {
        logic        is_end;
        logic        zero;
        logic [1:0]  trk_err;
        logic        sec_err;
        logic [1:0]  size_code;
        logic        prot_ok;
        logic        hdr_short;
        logic [31:0] bytes_after;
    } cmd_t;

    // Sector data size for flags bits 1:0
    function automatic logic [SIZE_W-1:0] entry_bytes(input logic [1:0] code);
        logic [SIZE_W-1:0] sz;
        case (code)
            2'd0:    sz = SIZE_W'(256);
            2'd1:    sz = SIZE_W'(128);
            2'd2:    sz = SIZE_W'(1024);
            2'd3:    sz = SIZE_W'(512);
            default: sz = SIZE_W'(256);
        endcase
        return sz;
    endfunction

    // Saturating add of a small increment to a 12-bit counter
    function automatic logic [11:0] sat_add(input logic [11:0] c, input logic [1:0] inc);
        logic [12:0] s;
        s = {1'b0, c} + {11'b0, inc};
        return s[12] ? COUNT_MAX : s[11:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dsiv_front.sv
// Front end: accepts input transactions, tracks entry continuity and
// classifies each used entry or end item into a command. Uses dsiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsiv_front import dsiv_pkg::*; #(
    parameter int ENTRIES_PER_HEADER = 2901
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic [7:0]  max_track,
    input  wire logic [7:0]  max_sector,
    input  wire logic        q_full,
    output logic             push,
    output cmd_t             push_cmd
);

    localparam int CNT_W = $clog2(ENTRIES_PER_HEADER + 1);

    logic [7:0]       prev_track_reg, prev_track_next;
    logic             first_entry_reg, first_entry_next;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;

    logic [7:0] trk, sec, flg, prot;
    logic       accept, is_end, in_window, free, cont_err, over_trk;

    assign trk  = s_tdata[7:0];
    assign sec  = s_tdata[15:8];
    assign flg  = s_tdata[23:16];
    assign prot = s_tdata[31:24];

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign is_end    = (s_tuser == OP_END);
    assign in_window = entry_count_reg < CNT_W'(ENTRIES_PER_HEADER);
    assign free      = (trk == FREE_MARK) || (sec == FREE_MARK);
    // nine-bit compare, so a previous 0xFF matches only 0xFF
    assign cont_err  = !first_entry_reg && (trk != prev_track_reg) &&
                       ({1'b0, trk} != ({1'b0, prev_track_reg} + 9'd1));
    assign over_trk  = trk > max_track;

    assign push = accept && (is_end || (in_window && !free));

    always_comb begin
        push_cmd.is_end      = is_end;
        push_cmd.zero        = (trk == 8'd0) && (sec == 8'd0) && (flg == 8'd0);
        push_cmd.trk_err     = {1'b0, cont_err} + {1'b0, over_trk};
        push_cmd.sec_err     = sec > max_sector;
        push_cmd.size_code   = flg[1:0];
        push_cmd.prot_ok     = (prot == PROTECT_ON) || (prot == PROTECT_OFF);
        push_cmd.hdr_short   = s_tdata[64];
        push_cmd.bytes_after = s_tdata[63:32];
    end

    always_comb begin
        prev_track_next  = prev_track_reg;
        first_entry_next = first_entry_reg;
        entry_count_next = entry_count_reg;
        if (accept) begin
            if (is_end) begin
                prev_track_next  = 8'd0;
                first_entry_next = 1'b1;
                entry_count_next = '0;
            end else if (in_window) begin
                prev_track_next  = trk;
                first_entry_next = 1'b0;
                entry_count_next = entry_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_track_reg  <= 8'd0;
            first_entry_reg <= 1'b1;
            entry_count_reg <= '0;
        end else begin
            prev_track_reg  <= prev_track_next;
            first_entry_reg <= first_entry_next;
            entry_count_reg <= entry_count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_W'(ENTRIES_PER_HEADER))
        else $error("entry count ran past the header size");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_end |=> first_entry_reg && entry_count_reg == '0)
        else $error("end item did not clear the front state");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("push while queue full");

endmodule

`default_nettype wire

>>> hw/rtl/dsiv_queue.sv
// Short command queue between front and back, register based.
// Uses cmd_t and queue sizing from dsiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsiv_queue import dsiv_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      q_full,
    output logic      q_valid,
    output cmd_t      q_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with count");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full && !pop |=> q_full)
        else $error("full queue lost a command without a pop");

endmodule

`default_nettype wire

>>> hw/rtl/dsiv_back.sv
// Back end: applies commands to the header counters and, on an end
// command, forms status and size in the output register. Uses dsiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsiv_back import dsiv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             pop,
    input  wire limits_t     limits,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    logic [11:0]       zero_count_reg, zero_count_next;
    logic [11:0]       trk_count_reg, trk_count_next;
    logic [11:0]       sec_count_reg, sec_count_next;
    logic [SIZE_W-1:0] size_sum_reg, size_sum_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        status_reg, status_next;
    logic [SIZE_W-1:0] data_bytes_reg, data_bytes_next;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = q_valid && (!q_cmd.is_end || out_free);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, data_bytes_reg, status_reg};

    always_comb begin
        if (q_cmd.hdr_short) begin
            status_next = STATUS_TOO_SMALL;
        end else if (!q_cmd.prot_ok) begin
            status_next = STATUS_INVALID;
        end else if (zero_count_reg >= limits.zero_limit) begin
            status_next = STATUS_INVALID;
        end else if (trk_count_reg >= limits.track_limit) begin
            status_next = STATUS_BAD_TRACKS;
        end else if (sec_count_reg >= limits.sector_limit) begin
            status_next = STATUS_BAD_SECTORS;
        end else if (q_cmd.bytes_after < {10'd0, size_sum_reg}) begin
            status_next = STATUS_TOO_SMALL;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_comb begin
        zero_count_next = zero_count_reg;
        trk_count_next  = trk_count_reg;
        sec_count_next  = sec_count_reg;
        size_sum_next   = size_sum_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        data_bytes_next = data_bytes_reg;
        if (pop) begin
            if (q_cmd.is_end) begin
                zero_count_next = 12'd0;
                trk_count_next  = 12'd0;
                sec_count_next  = 12'd0;
                size_sum_next   = '0;
                m_tvalid_next   = 1'b1;
                data_bytes_next = size_sum_reg;
            end else begin
                zero_count_next = sat_add(zero_count_reg, {1'b0, q_cmd.zero});
                trk_count_next  = sat_add(trk_count_reg, q_cmd.trk_err);
                sec_count_next  = sat_add(sec_count_reg, {1'b0, q_cmd.sec_err});
                size_sum_next   = size_sum_reg + entry_bytes(q_cmd.size_code);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_count_reg <= 12'd0;
            trk_count_reg  <= 12'd0;
            sec_count_reg  <= 12'd0;
            size_sum_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            zero_count_reg <= zero_count_next;
            trk_count_reg  <= trk_count_next;
            sec_count_reg  <= sec_count_next;
            size_sum_reg   <= size_sum_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload holds until taken
    always_ff @(posedge aclk) begin
        if (pop && q_cmd.is_end) begin
            status_reg     <= status_next;
            data_bytes_reg <= data_bytes_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_cmd.is_end |=> size_sum_reg == '0 && trk_count_reg == 12'd0)
        else $error("end command did not clear the counters");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !(pop && q_cmd.is_end))
        else $error("pending result overwritten");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> status_reg <= STATUS_BAD_SECTORS)
        else $error("status code out of range");

endmodule

`default_nettype wire

>>> hw/rtl/disk_image_sector_id_validator_top.sv
// Top level of the sector ID header validator: register port, front end,
// command queue and back end. Depends on dsiv_pkg, dsiv_front, dsiv_queue, dsiv_back.
//
//   channel  direction  handshake               payload
//   s_       in         s_tvalid / s_tready     s_tdata[71:0], s_tuser (opcode)
//   m_       out        m_tvalid / m_tready     m_tdata[31:0]
//   cfg      in         psel, penable, pwrite   paddr[4:0], pwdata, prdata
//
// One transaction per cycle on the input while the queue is not full; each passes
// front, queue and back in order. A result is loaded into the output register at the
// edge that pops its end item from the queue; an accepted end item is first written
// into a queue slot. The queue holds four commands; the input stalls only when it
// is full, which happens when an end item waits on a result not yet taken on m_.
// Reset is synchronous, active low, restores the limit registers and clears all counters.
`timescale 1ns / 1ps
`default_nettype none

module disk_image_sector_id_validator_top import dsiv_pkg::*; #(
    parameter int ENTRIES_PER_HEADER = 2901
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // track_id[7:0], sector_id[15:8], flag_bits[23:16], protect_byte[31:24],
    // bytes_after[63:32], header_short[64], zero[71:65]
    input  wire logic [71:0] s_tdata,
    // opcode[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], data_bytes[24:3], zero[31:25]
    output logic [31:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [11:0] zero_limit_reg, zero_limit_next;
    logic [11:0] track_limit_reg, track_limit_next;
    logic [11:0] sector_limit_reg, sector_limit_next;
    logic [7:0]  max_track_reg, max_track_next;
    logic [7:0]  max_sector_reg, max_sector_next;
    logic        wr_en;
    logic [2:0]  reg_idx;
    limits_t     limits;

    logic q_full, q_valid, push, pop;
    cmd_t push_cmd, q_cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb begin
        zero_limit_next   = zero_limit_reg;
        track_limit_next  = track_limit_reg;
        sector_limit_next = sector_limit_reg;
        max_track_next    = max_track_reg;
        max_sector_next   = max_sector_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ZERO_LIMIT:   zero_limit_next   = pwdata[11:0];
                REG_TRACK_LIMIT:  track_limit_next  = pwdata[11:0];
                REG_SECTOR_LIMIT: sector_limit_next = pwdata[11:0];
                REG_MAX_TRACK:    max_track_next    = pwdata[7:0];
                REG_MAX_SECTOR:   max_sector_next   = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ZERO_LIMIT:   prdata = {20'd0, zero_limit_reg};
            REG_TRACK_LIMIT:  prdata = {20'd0, track_limit_reg};
            REG_SECTOR_LIMIT: prdata = {20'd0, sector_limit_reg};
            REG_MAX_TRACK:    prdata = {24'd0, max_track_reg};
            REG_MAX_SECTOR:   prdata = {24'd0, max_sector_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_limit_reg   <= 12'd40;
            track_limit_reg  <= 12'd20;
            sector_limit_reg <= 12'd20;
            max_track_reg    <= 8'd80;
            max_sector_reg   <= 8'd32;
        end else begin
            zero_limit_reg   <= zero_limit_next;
            track_limit_reg  <= track_limit_next;
            sector_limit_reg <= sector_limit_next;
            max_track_reg    <= max_track_next;
            max_sector_reg   <= max_sector_next;
        end
    end

    always_comb begin
        limits.zero_limit   = zero_limit_reg;
        limits.track_limit  = track_limit_reg;
        limits.sector_limit = sector_limit_reg;
    end

    dsiv_front #(
        .ENTRIES_PER_HEADER(ENTRIES_PER_HEADER)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .max_track  (max_track_reg),
        .max_sector (max_sector_reg),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dsiv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    dsiv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .limits   (limits),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the sector ID header validator: streams headers into
// s_, checks each end-of-header status and data size on m_, programs limits over APB.
// Depends on dsiv_pkg and disk_image_sector_id_validator_top.
`timescale 1ns / 1ps

module tb_top;
    import dsiv_pkg::*;

    localparam int HDR_ENTRY_CAP   = 2901;
    localparam int SETTLE_CYCLES   = 16;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic        op;
        logic [7:0]  trk;
        logic [7:0]  sec;
        logic [7:0]  flg;
        logic [7:0]  prot;
        logic [31:0] avail;
        logic        hshort;
    } hdr_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [21:0] bytes;
    } hdr_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // track_id[7:0], sector_id[15:8], flag_bits[23:16], protect_byte[31:24],
    // bytes_after[63:32], header_short[64], zero[71:65]
    logic [71:0] s_tdata = '0;
    // opcode[0]
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[2:0], data_bytes[24:3], zero[31:25]
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hdr_item_t   header_stream[$];
    hdr_report_t pending_reports[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int          issued_count = 0;
    int          taken_count = 0;
    int          mismatch_count = 0;

    // Register copies used by the predictor
    logic [11:0] cfg_zero_lim = 12'd40;
    logic [11:0] cfg_trk_lim  = 12'd20;
    logic [11:0] cfg_sec_lim  = 12'd20;
    logic [7:0]  cfg_max_trk  = 8'd80;
    logic [7:0]  cfg_max_sec  = 8'd32;

    // Header state of the predictor
    logic [7:0]  hdr_prev_trk = '0;
    logic        hdr_first = 1'b1;
    logic [11:0] hdr_zero_cnt = '0;
    logic [11:0] hdr_trk_errs = '0;
    logic [11:0] hdr_sec_errs = '0;
    logic [21:0] hdr_bytes = '0;
    int          hdr_entries = 0;

    disk_image_sector_id_validator_top #(
        .ENTRIES_PER_HEADER(HDR_ENTRY_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [21:0] sector_bytes(input logic [1:0] code);
        case (code)
            2'd0:    return 22'd256;
            2'd1:    return 22'd128;
            2'd2:    return 22'd1024;
            default: return 22'd512;
        endcase
    endfunction

    function automatic logic [11:0] bumped(input logic [11:0] c);
        return (c == COUNT_MAX) ? c : c + 12'd1;
    endfunction

    // Advance the header state by one accepted transaction; queue a report on end items
    task automatic track_header(input logic op, input logic [7:0] trk, input logic [7:0] sec,
                                input logic [7:0] flg, input logic [7:0] prot,
                                input logic [31:0] avail, input logic hshort);
        logic [7:0]  prior;
        logic        had_prior;
        hdr_report_t rpt;
        if (op == OP_ENTRY) begin
            if (hdr_entries < HDR_ENTRY_CAP) begin
                hdr_entries++;
                prior = hdr_prev_trk;
                had_prior = !hdr_first;
                hdr_prev_trk = trk;
                hdr_first = 1'b0;
                if (trk != FREE_MARK && sec != FREE_MARK) begin
                    if (trk == 8'd0 && sec == 8'd0 && flg == 8'd0)
                        hdr_zero_cnt = bumped(hdr_zero_cnt);
                    // nine-bit compare: a previous 0xFF matches only 0xFF
                    if (had_prior && trk != prior && {1'b0, trk} != {1'b0, prior} + 9'd1)
                        hdr_trk_errs = bumped(hdr_trk_errs);
                    if (trk > cfg_max_trk)
                        hdr_trk_errs = bumped(hdr_trk_errs);
                    if (sec > cfg_max_sec)
                        hdr_sec_errs = bumped(hdr_sec_errs);
                    hdr_bytes = hdr_bytes + sector_bytes(flg[1:0]);
                end
            end
        end else begin
            if (hshort)
                rpt.status = STATUS_TOO_SMALL;
            else if (prot != PROTECT_ON && prot != PROTECT_OFF)
                rpt.status = STATUS_INVALID;
            else if (hdr_zero_cnt >= cfg_zero_lim)
                rpt.status = STATUS_INVALID;
            else if (hdr_trk_errs >= cfg_trk_lim)
                rpt.status = STATUS_BAD_TRACKS;
            else if (hdr_sec_errs >= cfg_sec_lim)
                rpt.status = STATUS_BAD_SECTORS;
            else if (avail < {10'd0, hdr_bytes})
                rpt.status = STATUS_TOO_SMALL;
            else
                rpt.status = STATUS_OK;
            rpt.bytes = hdr_bytes;
            pending_reports.push_back(rpt);
            hdr_prev_trk = '0;
            hdr_first = 1'b1;
            hdr_zero_cnt = '0;
            hdr_trk_errs = '0;
            hdr_sec_errs = '0;
            hdr_bytes = '0;
            hdr_entries = 0;
        end
    endtask

    // Driver: present the next pending transaction once the previous one is taken
    always @(negedge aclk) begin
        hdr_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (taken_count == issued_count) begin
                if (header_stream.size() > 0 &&
                    !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 85) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7))) begin
                    it = header_stream.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= it.op;
                    s_tdata <= {7'd0, it.hshort, it.avail, it.prot, it.flg, it.sec, it.trk};
                    issued_count++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 85) ||
                          (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7));
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge aclk) begin
        hdr_report_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                taken_count++;
                track_header(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                             s_tdata[31:24], s_tdata[63:32], s_tdata[64]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result status %0d data_bytes %0d",
                             $time, m_tdata[2:0], m_tdata[24:3]);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[24:3] !== want.bytes) begin
                        $display("%0t: data_bytes expected %0d actual %0d",
                                 $time, want.bytes, m_tdata[24:3]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_ZERO_LIMIT:   cfg_zero_lim = value[11:0];
            REG_TRACK_LIMIT:  cfg_trk_lim = value[11:0];
            REG_SECTOR_LIMIT: cfg_sec_lim = value[11:0];
            REG_MAX_TRACK:    cfg_max_trk = value[7:0];
            REG_MAX_SECTOR:   cfg_max_sec = value[7:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(input logic [11:0] zl, input logic [11:0] tl,
                              input logic [11:0] sl, input logic [7:0] mt,
                              input logic [7:0] ms);
        cfg_write(REG_ZERO_LIMIT, {20'd0, zl});
        cfg_write(REG_TRACK_LIMIT, {20'd0, tl});
        cfg_write(REG_SECTOR_LIMIT, {20'd0, sl});
        cfg_write(REG_MAX_TRACK, {24'd0, mt});
        cfg_write(REG_MAX_SECTOR, {24'd0, ms});
    endtask

    // Entry fields are random on end items and end fields random on entries
    task automatic push_entry(input logic [7:0] trk, input logic [7:0] sec,
                              input logic [7:0] flg);
        hdr_item_t it;
        it.op = OP_ENTRY;
        it.trk = trk;
        it.sec = sec;
        it.flg = flg;
        it.prot = 8'($urandom);
        it.avail = $urandom;
        it.hshort = 1'($urandom);
        header_stream.push_back(it);
    endtask

    task automatic push_end(input logic [7:0] prot, input logic [31:0] avail,
                            input logic hshort);
        hdr_item_t it;
        it.op = OP_END;
        it.trk = 8'($urandom);
        it.sec = 8'($urandom);
        it.flg = 8'($urandom);
        it.prot = prot;
        it.avail = avail;
        it.hshort = hshort;
        header_stream.push_back(it);
    endtask

    // Wait until every transaction is taken and every report has arrived
    task automatic wait_idle();
        while (header_stream.size() != 0 || taken_count != issued_count ||
               pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random_headers(input int quota);
        int          made;
        int          n;
        int          kind;
        int          i;
        int          pick;
        logic [7:0]  walk;
        logic [7:0]  e_trk;
        logic [7:0]  e_sec;
        logic [7:0]  e_flg;
        logic [7:0]  prot;
        logic [31:0] est;
        logic [31:0] avail;
        made = 0;
        while (made < quota) begin
            if ($urandom_range(0, 5) == 0)
                idle_mode = idle_mode_t'($urandom_range(0, 3));
            // mostly well-formed headers; one kind of padding, one of pure noise
            kind = $urandom_range(0, 9);
            if (kind == 9)
                n = $urandom_range(20, 80);
            else if (kind == 6)
                n = $urandom_range(1, 50);
            else
                n = $urandom_range(0, 12);
            walk = 8'($urandom_range(0, cfg_max_trk));
            est = 0;
            for (i = 0; i < n; i++) begin
                e_flg = 8'($urandom);
                e_sec = 8'($urandom_range(0, cfg_max_sec));
                if (kind == 6 && $urandom_range(0, 4) != 0) begin
                    walk = 8'd0;
                    e_sec = 8'd0;
                    e_flg = 8'd0;
                end else if (kind == 7) begin
                    walk = 8'($urandom);
                    e_sec = 8'($urandom);
                end else begin
                    if ($urandom_range(0, 2) == 0 && walk < 8'hFE)
                        walk++;
                    if (kind == 8 && $urandom_range(0, 3) == 0)
                        walk = 8'($urandom_range(0, 254));
                    if ($urandom_range(0, 9) == 0)
                        e_sec = 8'($urandom_range(0, 254));
                end
                e_trk = walk;
                if (kind != 6 && $urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 2) == 0)
                        e_trk = FREE_MARK;
                    else
                        e_sec = FREE_MARK;
                end
                if (e_trk != FREE_MARK && e_sec != FREE_MARK)
                    est += sector_bytes(e_flg[1:0]);
                push_entry(e_trk, e_sec, e_flg);
            end
            pick = $urandom_range(0, 9);
            prot = (pick < 4) ? PROTECT_OFF : (pick < 8) ? PROTECT_ON : 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                avail = est;
            else if (pick < 6)
                avail = (est > 0) ? est - 1 : 0;
            else if (pick < 8)
                avail = est + $urandom_range(0, 700);
            else if (pick == 8)
                avail = 0;
            else
                avail = $urandom;
            push_end(prot, avail, $urandom_range(0, 19) == 0);
            made += n + 1;
            // hold back so idle mode changes land while traffic flows
            while (header_stream.size() > 2)
                @(posedge aclk);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed headers at reset limits
        push_entry(8'd0, 8'd0, 8'd0);       // all-zero first entry
        push_entry(8'd0, 8'd1, 8'h01);
        push_entry(8'd1, 8'd32, 8'h02);     // sector at its limit
        push_entry(8'd1, 8'd33, 8'h03);     // sector above limit
        push_entry(FREE_MARK, 8'd5, 8'hFC); // free, still moves previous track to 0xFF
        push_entry(8'd0, 8'd3, 8'h00);      // breaks continuity after 0xFF
        push_entry(8'd81, 8'd0, 8'h00);     // jump and above max track
        push_entry(8'h10, FREE_MARK, 8'h7F);
        push_entry(8'hFE, 8'hFE, 8'hFF);
        push_end(PROTECT_ON, 32'hFFFF_FFFF, 1'b0);
        push_end(PROTECT_OFF, 32'd0, 1'b0);  // empty header
        push_entry(8'd5, 8'd5, 8'hAA);
        push_end(PROTECT_OFF, 32'd0, 1'b1);
        push_entry(8'd5, 8'd5, 8'h55);
        push_end(8'h01, 32'hFFFF_FFFF, 1'b0);
        push_entry(8'd7, 8'd1, 8'h02);
        push_end(PROTECT_OFF, 32'd1023, 1'b0);
        wait_idle();
        queue_random_headers(110);
        wait_idle();

        // Lowest limits; writes to unused addresses must change nothing
        idle_mode = IDLE_NONE;
        set_limits(12'd1, 12'd1, 12'd1, 8'd0, 8'd0);
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        push_entry(8'd0, 8'd0, 8'd0);
        push_end(PROTECT_OFF, 32'd1000, 1'b0);
        push_entry(8'd1, 8'd0, 8'd0);
        push_end(PROTECT_OFF, 32'd1000, 1'b0);
        push_entry(8'd0, 8'd1, 8'd0);
        push_end(PROTECT_ON, 32'd1000, 1'b0);
        wait_idle();
        queue_random_headers(110);
        wait_idle();

        set_limits(12'd4095, 12'd4095, 12'd4095, 8'd254, 8'd254);
        queue_random_headers(110);
        wait_idle();

        repeat (2) begin
            set_limits(12'($urandom_range(1, 60)), 12'($urandom_range(1, 30)),
                       12'($urandom_range(1, 30)), 8'($urandom_range(0, 254)),
                       8'($urandom_range(0, 254)));
            queue_random_headers(110);
            wait_idle();
        end

        set_limits(12'd40, 12'd20, 12'd20, 8'd80, 8'd32);
        queue_random_headers(110);
        wait_idle();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
